@@ rtl/vpid_pkg.sv @@
`default_nettype none

package vpid_pkg;

	// Target clamp and fallback threshold, speed with 8 fractional bits
	localparam logic signed [12:0] TGT_LIM   = 13'sd3840;
	localparam logic signed [12:0] ONE_SPEED = 13'sd256;

	// Term limits with 16 fractional bits
	localparam logic signed [23:0] INTEG_LIM = 24'sd2621440;
	localparam logic signed [23:0] DERIV_LIM = 24'sd4587520;
	localparam logic signed [24:0] SUM_LIM   = 25'sd9830400;

	// Largest drive in hundredths
	localparam logic signed [14:0] DRIVE_LIM = 15'sd15000;

	typedef enum logic [2:0] {
		REG_PROP_GAIN  = 3'd0,
		REG_INTEG_GAIN = 3'd1,
		REG_DERIV_GAIN = 3'd2,
		REG_FB_FWD     = 3'd3,
		REG_FB_BWD     = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		FB_ZERO,
		FB_FWD,
		FB_BWD
	} fb_sel_t;

	typedef struct packed {
		logic [15:0] prop;
		logic [15:0] integ;
		logic [15:0] deriv;
		logic [15:0] fb_fwd;
		logic [15:0] fb_bwd;
	} gains_t;

	// Products handed from the front stage to the accumulator
	typedef struct packed {
		logic               lost;
		fb_sel_t            fb_sel;
		logic [15:0]        fb_gain;
		logic               d_en;
		logic signed [32:0] p_prod;
		logic signed [32:0] i_prod;
		logic signed [33:0] d_prod;
	} term_t;

endpackage

`default_nettype wire

@@ rtl/velocity_pid_with_lost_target_fallback_core.sv @@
// Velocity PID with lost-target fallback drive.
// Input stream (s_*): one request per control tick. s_tdata carries target_speed
// and measured_speed, s_tuser carries target_lost. Output stream (m_*): one
// drive_out result per request, in hundredths, saturated to +-15000.
// Configuration: cfg_wr_en/cfg_index/cfg_data write the five gains (indexes
// 0..4); other indexes are ignored. Write only while no request is in flight.
// Path: an accepted request passes through the input register, product stage,
// sum stage and output register before its result shows on m_tvalid.
// Throughput: one request per cycle while m_tready does not stall the output; the
// integrator update in the sum stage is the feedback loop that sets this.
// Stall: when m_tready is low the output register holds; stages behind it
// keep filling empty slots, and s_tready drops only when every stage is full.
// Reset: arst_n clears all valid bits, the gains, the integrator and the
// stored previous error, so the first tick after reset has no D term.
`default_nettype none

module velocity_pid_with_lost_target_fallback_core import vpid_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] target_speed, [31:16] measured_speed
	input  logic        s_tuser,   // [0] target_lost
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [14:0] drive_out, [15] zero
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	gains_t gains_q;

	logic               en1;
	logic               en2;
	logic               en3;
	logic               en_out;
	logic               valid_s1;
	logic               valid_s2;
	logic               valid_s3;
	term_t              term_s2;
	logic signed [24:0] sum_s3;
	logic signed [14:0] drive_q;

	// Gain registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q <= '0;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_PROP_GAIN:  gains_q.prop   <= cfg_data;
				REG_INTEG_GAIN: gains_q.integ  <= cfg_data;
				REG_DERIV_GAIN: gains_q.deriv  <= cfg_data;
				REG_FB_FWD:     gains_q.fb_fwd <= cfg_data;
				REG_FB_BWD:     gains_q.fb_bwd <= cfg_data;
				default:        gains_q        <= gains_q;
			endcase
		end
	end

	// Advance a stage when it is empty or the stage ahead advances
	assign en_out   = !m_tvalid || m_tready;
	assign en3      = !valid_s3 || en_out;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign s_tready = en1;

	vpid_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.en1            (en1),
		.en2            (en2),
		.in_valid       (s_tvalid),
		.target_speed   (s_tdata[15:0]),
		.measured_speed (s_tdata[31:16]),
		.target_lost    (s_tuser),
		.gains          (gains_q),
		.valid_s1       (valid_s1),
		.valid_s2       (valid_s2),
		.term_s2        (term_s2)
	);

	vpid_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.en3      (en3),
		.valid_s2 (valid_s2),
		.term_s2  (term_s2),
		.valid_s3 (valid_s3),
		.sum_s3   (sum_s3)
	);

	vpid_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.en_out      (en_out),
		.valid_s3    (valid_s3),
		.sum_s3      (sum_s3),
		.out_valid_q (m_tvalid),
		.drive_q     (drive_q)
	);

	assign m_tdata = {1'b0, drive_q};

	a_no_accept_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_s3 && m_tvalid && !m_tready) |-> !s_tready)
		else $error("request taken with every stage full");

	a_bubble_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_s1) |-> s_tready)
		else $error("input refused with empty input stage");

endmodule

`default_nettype wire

@@ rtl/vpid_front.sv @@
`default_nettype none

module vpid_front import vpid_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en1,
	input  logic        en2,
	input  logic        in_valid,
	input  logic [15:0] target_speed,
	input  logic [15:0] measured_speed,
	input  logic        target_lost,
	input  gains_t      gains,
	output logic        valid_s1,
	output logic        valid_s2,
	output term_t       term_s2
);

	logic signed [15:0] tgt_s1;
	logic signed [15:0] meas_s1;
	logic               lost_s1;

	logic signed [16:0] prev_err_q;
	logic               prev_valid_q;

	logic signed [12:0] tgt_c;
	logic signed [16:0] err;
	logic signed [17:0] diff;
	logic signed [16:0] pg;
	logic signed [16:0] ig;
	logic signed [16:0] dg;
	term_t              term_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			tgt_s1  <= $signed(target_speed);
			meas_s1 <= $signed(measured_speed);
			lost_s1 <= target_lost;
		end
	end

	always_comb begin
		if (tgt_s1 > TGT_LIM) begin
			tgt_c = TGT_LIM;
		end else if (tgt_s1 < -TGT_LIM) begin
			tgt_c = -TGT_LIM;
		end else begin
			tgt_c = tgt_s1[12:0];
		end
		err  = {{4{tgt_c[12]}}, tgt_c} - {meas_s1[15], meas_s1};
		diff = {err[16], err} - {prev_err_q[16], prev_err_q};
		pg   = $signed({1'b0, gains.prop});
		ig   = $signed({1'b0, gains.integ});
		dg   = $signed({1'b0, gains.deriv});

		term_d.lost   = lost_s1;
		term_d.d_en   = prev_valid_q;
		term_d.p_prod = err * pg;
		term_d.i_prod = err * ig;
		term_d.d_prod = diff * dg;
		if (tgt_c > ONE_SPEED) begin
			term_d.fb_sel  = FB_FWD;
			term_d.fb_gain = gains.fb_fwd;
		end else if (tgt_c < -ONE_SPEED) begin
			term_d.fb_sel  = FB_BWD;
			term_d.fb_gain = gains.fb_bwd;
		end else begin
			term_d.fb_sel  = FB_ZERO;
			term_d.fb_gain = 16'd0;
		end
	end

	// Previous error follows the item as it leaves this stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q   <= '0;
			prev_valid_q <= 1'b0;
		end else if (valid_s1 && en2) begin
			if (lost_s1) begin
				prev_err_q   <= '0;
				prev_valid_q <= 1'b0;
			end else begin
				prev_err_q   <= err;
				prev_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && valid_s1) begin
			term_s2 <= term_d;
		end
	end

	a_lost_clears_prev: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && en2 && lost_s1) |=> (!prev_valid_q && prev_err_q == 17'sd0))
		else $error("lost target did not clear previous error");

	a_normal_sets_prev: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && en2 && !lost_s1) |=> (prev_valid_q && term_d.d_en))
		else $error("previous error not marked valid after normal tick");

endmodule

`default_nettype wire

@@ rtl/vpid_accum.sv @@
`default_nettype none

module vpid_accum import vpid_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en3,
	input  logic               valid_s2,
	input  term_t              term_s2,
	output logic               valid_s3,
	output logic signed [24:0] sum_s3
);

	logic signed [23:0] integ_q;

	logic signed [33:0] integ_sum;
	logic signed [23:0] integ_nx;
	logic signed [34:0] d_neg;
	logic signed [23:0] d_c;
	logic [28:0]        fb_val;
	logic signed [34:0] sum_raw;
	logic signed [24:0] sum_c;

	always_comb begin
		integ_sum = {{10{integ_q[23]}}, integ_q} + {term_s2.i_prod[32], term_s2.i_prod};
		if (integ_sum > INTEG_LIM) begin
			integ_nx = INTEG_LIM;
		end else if (integ_sum < -INTEG_LIM) begin
			integ_nx = -INTEG_LIM;
		end else begin
			integ_nx = integ_sum[23:0];
		end

		d_neg = -{term_s2.d_prod[33], term_s2.d_prod};
		if (!term_s2.d_en) begin
			d_c = '0;
		end else if (d_neg > DERIV_LIM) begin
			d_c = DERIV_LIM;
		end else if (d_neg < -DERIV_LIM) begin
			d_c = -DERIV_LIM;
		end else begin
			d_c = d_neg[23:0];
		end

		// Fallback drive magnitude: gain * 20 * 256
		fb_val = {1'b0, term_s2.fb_gain, 12'd0} + {3'd0, term_s2.fb_gain, 10'd0};

		if (term_s2.lost) begin
			case (term_s2.fb_sel)
				FB_FWD:  sum_raw = -$signed({6'd0, fb_val});
				FB_BWD:  sum_raw = $signed({6'd0, fb_val});
				default: sum_raw = '0;
			endcase
		end else begin
			sum_raw = -{{2{term_s2.p_prod[32]}}, term_s2.p_prod}
				- {{11{integ_nx[23]}}, integ_nx}
				+ {{11{d_c[23]}}, d_c};
		end

		if (sum_raw > SUM_LIM) begin
			sum_c = SUM_LIM;
		end else if (sum_raw < -SUM_LIM) begin
			sum_c = -SUM_LIM;
		end else begin
			sum_c = sum_raw[24:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (valid_s2 && en3 && !term_s2.lost) begin
			integ_q <= integ_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && valid_s2) begin
			sum_s3 <= sum_c;
		end
	end

	a_lost_holds_integ: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && en3 && term_s2.lost) |=> $stable(integ_q))
		else $error("integrator moved on a lost-target tick");

	a_stall_holds_integ: assert property (@(posedge clk) disable iff (!arst_n)
		(!en3) |=> $stable(integ_q))
		else $error("integrator moved while stage was stalled");

endmodule

`default_nettype wire

@@ rtl/vpid_scale.sv @@
`default_nettype none

module vpid_scale import vpid_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en_out,
	input  logic               valid_s3,
	input  logic signed [24:0] sum_s3,
	output logic               out_valid_q,
	output logic signed [14:0] drive_q
);

	logic signed [31:0] sum_ext;
	logic signed [31:0] scaled;
	logic signed [31:0] adj;
	logic signed [14:0] drive_d;

	// Times 100 as 64 + 32 + 4, then truncate toward zero by 2^16.
	// The sum limit makes the result fall inside the drive limit already.
	always_comb begin
		sum_ext = {{7{sum_s3[24]}}, sum_s3};
		scaled  = (sum_ext <<< 6) + (sum_ext <<< 5) + (sum_ext <<< 2);
		adj     = scaled[31] ? (scaled + 32'sd65535) : scaled;
		drive_d = adj[30:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && valid_s3) begin
			drive_q <= drive_d;
		end
	end

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		(en_out && valid_s3) |=> (drive_q <= DRIVE_LIM && drive_q >= -DRIVE_LIM))
		else $error("drive out of range");

	a_drive_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(en_out && valid_s3 && !sum_s3[24]) |=> !drive_q[14])
		else $error("drive sign disagrees with sum");

endmodule

`default_nettype wire
